FILE: src/srm_pkg.sv
// ----------------------------------------------------------------------------
// srm_pkg
// Types and constants shared by the scanline region mirror modules.
// ----------------------------------------------------------------------------
package srm_pkg;

   localparam int unsigned PIXEL_W    = 24;
   localparam int unsigned COL_CFG_W  = 12;
   localparam int unsigned ROW_CFG_W  = 16;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_COL     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_COL    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TOP_ROW      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BOTTOM_ROW   = 3'd5;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [PIXEL_W-1:0] pixel;
   } req_type;

   typedef struct packed {
      logic               out_valid;
      logic [PIXEL_W-1:0] out_pixel;
      logic               end_of_row;
   } rsp_type;

   typedef struct packed {
      logic [COL_CFG_W-1:0] image_width;
      logic [ROW_CFG_W-1:0] image_height;
      logic [COL_CFG_W-1:0] left_col;
      logic [COL_CFG_W-1:0] right_col;
      logic [ROW_CFG_W-1:0] top_row;
      logic [ROW_CFG_W-1:0] bottom_row;
   } cfg_type;

   typedef struct packed {
      logic present;
      logic end_of_row;
   } meta_type;

endpackage

FILE: src/scanline_region_mirror_core.sv
// ----------------------------------------------------------------------------
// scanline_region_mirror_core
// Mirrors a column span of selected rows of a 24-bit pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one item per pixel in stored row order (kind pixel), or a
//   flush item (kind flush) to drain the last row. Every item gives exactly
//   one rsp item: the previous row's pixel at the same column, with the span
//   left_col..right_col mirrored when that row lies in top_row..bottom_row.
//   rsp out_valid is 0 while no previous row exists.
//   csr port: write-only registers, written while the block is idle.
// Timing:
//   One item per cycle sustained while rsp_ready stays high. An item's result
//   passes the row-bank RAM read, registered at the accepting edge, and then
//   the output register, which loads once it is empty or being emptied.
//   One RAM read per item and one write per pixel item set the rate.
// Reset:
//   Counters, bank select and pipeline valids clear; no previous row exists.
//   Row-bank contents are undefined until written.
// Stall:
//   With rsp_ready low the output register and the read stage hold; req_ready
//   drops once both are full and rises in the cycle rsp_ready returns.
// ----------------------------------------------------------------------------
module scanline_region_mirror_core
   import srm_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_item,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned AW = $clog2(MAX_WIDTH) + 1;

   cfg_type            cfg_ff, cfg_in;
   logic               accept;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [AW-1:0]      rd_addr;
   logic [PIXEL_W-1:0] wr_data;
   logic [PIXEL_W-1:0] rd_data;
   meta_type           meta;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  cfg_in.image_width  = csr_wdata[COL_CFG_W-1:0];
            REG_IMAGE_HEIGHT: cfg_in.image_height = csr_wdata[ROW_CFG_W-1:0];
            REG_LEFT_COL:     cfg_in.left_col     = csr_wdata[COL_CFG_W-1:0];
            REG_RIGHT_COL:    cfg_in.right_col    = csr_wdata[COL_CFG_W-1:0];
            REG_TOP_ROW:      cfg_in.top_row      = csr_wdata[ROW_CFG_W-1:0];
            REG_BOTTOM_ROW:   cfg_in.bottom_row   = csr_wdata[ROW_CFG_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= 12'd2048;
         cfg_ff.image_height <= 16'd1;
         cfg_ff.left_col     <= 12'd1;
         cfg_ff.right_col    <= 12'd2;
         cfg_ff.top_row      <= 16'd1;
         cfg_ff.bottom_row   <= 16'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign accept = req_valid && req_ready;

   srm_addr_ctrl #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_addr_ctrl (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .accept  (accept),
      .item    (req_item),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .meta    (meta)
   );

   srm_row_banks #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_row_banks (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   srm_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .meta       (meta),
      .rd_data    (rd_data),
      .can_accept (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

endmodule

FILE: src/srm_row_banks.sv
// ----------------------------------------------------------------------------
// srm_row_banks
// Two row banks in one synchronous RAM: one write port, one registered read.
// ----------------------------------------------------------------------------
module srm_row_banks
   import srm_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = 2048
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(MAX_WIDTH):0]       wr_addr,
   input  logic [PIXEL_W-1:0]               wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(MAX_WIDTH):0]       rd_addr,
   output logic [PIXEL_W-1:0]               rd_data
);

   // bank select is the address MSB, so each bank spans a power of two
   localparam int unsigned DEPTH = 2 ** ($clog2(MAX_WIDTH) + 1);

   logic [PIXEL_W-1:0] mem [DEPTH];
   logic [PIXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/srm_addr_ctrl.sv
// ----------------------------------------------------------------------------
// srm_addr_ctrl
// Column/row counters, bank select, mirror address and region tracking.
// ----------------------------------------------------------------------------
module srm_addr_ctrl
   import srm_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = 2048
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cfg_type                     cfg,
   input  logic                        accept,
   input  req_type                     item,
   output logic                        wr_en,
   output logic [$clog2(MAX_WIDTH):0]  wr_addr,
   output logic [PIXEL_W-1:0]          wr_data,
   output logic [$clog2(MAX_WIDTH):0]  rd_addr,
   output meta_type                    meta
);

   localparam int unsigned CW = $clog2(MAX_WIDTH);

   logic [CW-1:0]        col_ff, col_in;
   logic [ROW_CFG_W-1:0] row_ff, row_in;
   logic                 bank_ff, bank_in;
   logic                 present_ff, present_in;
   logic                 region_ff, region_in;

   logic [CW:0]          w_eff;
   logic [CW:0]          c_inc;
   logic                 last;
   logic [31:0]          w32, l32, r32, c32, src32;
   logic                 span_ok, in_span;
   logic [CW-1:0]        src_col;
   logic signed [ROW_CFG_W:0] row_num;
   logic                 row_hit;
   logic [ROW_CFG_W-1:0] row_next;
   logic                 flush;

   always_comb begin
      if (cfg.image_width == '0) begin
         w32 = 32'd1;
      end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
         w32 = 32'(MAX_WIDTH);
      end else begin
         w32 = 32'(cfg.image_width);
      end
      w_eff = w32[CW:0];
   end

   assign c_inc = {1'b0, col_ff} + (CW+1)'(1);
   assign last  = (c_inc >= w_eff);
   assign flush = (item.kind == KIND_FLUSH);

   assign l32 = 32'(cfg.left_col);
   assign r32 = 32'(cfg.right_col);
   assign c32 = 32'(col_ff);

   assign span_ok = (l32 != 32'd0) && (l32 <= r32) && (r32 <= w32);
   assign in_span = (c32 + 32'd1 >= l32) && (c32 + 32'd1 <= r32);
   assign src32   = l32 + r32 - 32'd2 - c32;
   assign src_col = (region_ff && span_ok && in_span) ? src32[CW-1:0] : col_ff;

   // row number counted down from image_height, so the last row of a frame is 1
   assign row_num = $signed({1'b0, cfg.image_height}) - $signed({1'b0, row_ff});
   assign row_hit = (row_num >= $signed({1'b0, cfg.top_row}))
                 && (row_num <= $signed({1'b0, cfg.bottom_row}));
   assign row_next = row_ff + ROW_CFG_W'(1);

   assign rd_addr = {~bank_ff, src_col};
   assign wr_addr = {bank_ff, col_ff};
   assign wr_data = item.pixel;
   assign wr_en   = accept && !flush;

   assign meta.present    = present_ff;
   assign meta.end_of_row = present_ff && last;

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      bank_in    = bank_ff;
      present_in = present_ff;
      region_in  = region_ff;
      if (accept) begin
         if (flush) begin
            if (present_ff) begin
               if (last) begin
                  col_in     = '0;
                  present_in = 1'b0;
                  row_in     = '0;
               end else begin
                  col_in = c_inc[CW-1:0];
               end
            end
         end else if (last) begin
            col_in     = '0;
            region_in  = row_hit;
            present_in = 1'b1;
            bank_in    = ~bank_ff;
            row_in     = (row_next >= cfg.image_height) ? '0 : row_next;
         end else begin
            col_in = c_inc[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         bank_ff    <= 1'b0;
         present_ff <= 1'b0;
         region_ff  <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         bank_ff    <= bank_in;
         present_ff <= present_in;
         region_ff  <= region_in;
      end
   end

endmodule

FILE: src/srm_out_stage.sv
// ----------------------------------------------------------------------------
// srm_out_stage
// RAM read stage and output register with stall handling.
// ----------------------------------------------------------------------------
module srm_out_stage
   import srm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  meta_type           meta,
   input  logic [PIXEL_W-1:0] rd_data,
   output logic               can_accept,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_item
);

   logic     s1_valid_ff, s1_valid_in;
   meta_type s1_meta_ff, s1_meta_in;
   logic     out_valid_ff, out_valid_in;
   rsp_type  out_item_ff, out_item_in;
   logic     s1_move;

   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign can_accept = !s1_valid_ff || s1_move;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_meta_in   = s1_meta_ff;
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (s1_move) begin
         s1_valid_in            = 1'b0;
         out_valid_in           = 1'b1;
         out_item_in.out_valid  = s1_meta_ff.present;
         out_item_in.out_pixel  = s1_meta_ff.present ? rd_data : '0;
         out_item_in.end_of_row = s1_meta_ff.end_of_row;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_meta_in  = meta;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_meta_ff  <= s1_meta_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

FILE: verif/scanline_region_mirror_core_tb.sv
// ----------------------------------------------------------------------------
// scanline_region_mirror_core_tb
// Self-checking bench for the scanline region mirror. Streams pixel and flush
// items under random idling on both channels, tracks the row banks, counters
// and register shadow locally, and compares every result item field by field
// with the oldest prediction. Directed cases cover pixel extremes, flushes,
// width clamping, bad mirror spans, row wrap, mid-row width shrink and output
// backpressure; random frames follow.
// ----------------------------------------------------------------------------
module scanline_region_mirror_core_tb;
   import srm_pkg::*;

   localparam int MAX_W       = 2048;
   localparam int QUIET_LIMIT = 1000;
   localparam int HOLD_CYCLES = 60;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_item = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_item;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   scanline_region_mirror_core #(.MAX_WIDTH(MAX_W)) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_item     (req_item),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_item     (rsp_item),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // local copy of the row banks, counters and registers
   logic [PIXEL_W-1:0] row_store [2][MAX_W];
   int unsigned        col_pos = 0;
   int unsigned        row_idx = 0;
   bit                 bank_sel = 1'b0;
   bit                 have_prev = 1'b0;
   bit                 prev_mirrored = 1'b0;
   cfg_type            shadow_cfg = '{12'd2048, 16'd1, 12'd1, 12'd2, 16'd1, 16'd1};

   rsp_type            due_pixels [$];
   rsp_type            due_head;
   int                 mismatch_count = 0;
   int                 stream_count = 0;
   int                 quiet_cycles = 0;
   bit                 tx_gaps = 1'b1;
   bit                 rx_gaps = 1'b1;
   int                 hold_token = 0;
   int                 hold_token_seen = 0;
   int                 hold_left = 0;
   int                 stall_left = 0;

   function automatic int unsigned active_width();
      if (shadow_cfg.image_width == 0) return 1;
      if (shadow_cfg.image_width > MAX_W) return MAX_W;
      return shadow_cfg.image_width;
   endfunction

   function automatic logic [PIXEL_W-1:0] previous_pixel(int unsigned c, int unsigned w);
      int unsigned src;
      int unsigned lc;
      int unsigned rc;
      src = c;
      lc  = shadow_cfg.left_col;
      rc  = shadow_cfg.right_col;
      if (prev_mirrored && lc != 0 && lc <= rc && rc <= w && c + 1 >= lc && c + 1 <= rc)
         src = (lc - 1) + (rc - 1) - c;
      if (src >= MAX_W) src = MAX_W - 1;
      return row_store[bank_sel ^ 1'b1][src];
   endfunction

   function automatic rsp_type mirror_step(req_type it);
      int unsigned w;
      int unsigned c;
      int          rownum;
      bit          last;
      rsp_type     r;
      w = active_width();
      c = col_pos;
      if (c >= MAX_W) c = MAX_W - 1;
      last = (c + 1 >= w);
      r = '0;
      if (it.kind == KIND_FLUSH && !have_prev) return r;
      if (have_prev) begin
         r.out_valid  = 1'b1;
         r.out_pixel  = previous_pixel(c, w);
         r.end_of_row = last;
      end
      if (it.kind == KIND_FLUSH) begin
         col_pos = last ? 0 : c + 1;
         if (last) begin
            have_prev = 1'b0;
            row_idx   = 0;
         end
         return r;
      end
      row_store[bank_sel][c] = it.pixel;
      if (last) begin
         rownum = int'(shadow_cfg.image_height) - int'(row_idx);
         prev_mirrored = rownum >= int'(shadow_cfg.top_row) &&
                         rownum <= int'(shadow_cfg.bottom_row);
         have_prev = 1'b1;
         bank_sel  = ~bank_sel;
         col_pos   = 0;
         row_idx   = (row_idx + 1) % 65536;
         if (row_idx >= shadow_cfg.image_height) row_idx = 0;
      end else begin
         col_pos = c + 1;
      end
      return r;
   endfunction

   function automatic logic [PIXEL_W-1:0] any_pixel();
      return PIXEL_W'($urandom);
   endfunction

   function automatic cfg_type make_cfg(int w, int h, int l, int r, int t, int b);
      cfg_type s;
      s.image_width  = COL_CFG_W'(w);
      s.image_height = ROW_CFG_W'(h);
      s.left_col     = COL_CFG_W'(l);
      s.right_col    = COL_CFG_W'(r);
      s.top_row      = ROW_CFG_W'(t);
      s.bottom_row   = ROW_CFG_W'(b);
      return s;
   endfunction

   function automatic cfg_type random_cfg();
      int w;
      int weff;
      int h;
      int l;
      int r;
      int t;
      int b;
      case ($urandom_range(0, 9))
         0: w = 0;
         1, 2: w = $urandom_range(13, 48);
         default: w = $urandom_range(1, 12);
      endcase
      weff = (w == 0) ? 1 : w;
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 8);
      l = $urandom_range(1, weff);
      r = $urandom_range(l, weff);
      case ($urandom_range(0, 9))
         0: l = 0;
         1: begin
            l = $urandom_range(2, weff + 1);
            r = $urandom_range(1, l - 1);
         end
         2: r = $urandom_range(weff + 1, 4095);
         default: ;
      endcase
      t = h - int'($urandom_range(0, 8));
      if (t < 0) t = 0;
      b = t + int'($urandom_range(0, 8));
      if (b > 65535) b = 65535;
      if ($urandom_range(0, 9) == 0) begin
         t = $urandom_range(0, 65535);
         b = $urandom_range(0, 65535);
      end
      return make_cfg(w, h, l, r, t, b);
   endfunction

   task automatic send_item(logic kind, logic [PIXEL_W-1:0] px);
      req_type it;
      it.kind  = kind;
      it.pixel = px;
      if (tx_gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      if (kind == KIND_PIXEL || have_prev) stream_count++;
      due_pixels.push_back(mirror_step(it));
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
   endtask

   task automatic apply_settings(cfg_type s);
      write_reg(REG_IMAGE_WIDTH,  CSR_DATA_W'(s.image_width));
      write_reg(REG_IMAGE_HEIGHT, CSR_DATA_W'(s.image_height));
      write_reg(REG_LEFT_COL,     CSR_DATA_W'(s.left_col));
      write_reg(REG_RIGHT_COL,    CSR_DATA_W'(s.right_col));
      write_reg(REG_TOP_ROW,      CSR_DATA_W'(s.top_row));
      write_reg(REG_BOTTOM_ROW,   CSR_DATA_W'(s.bottom_row));
      csr_write_en <= 1'b0;
      shadow_cfg = s;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (due_pixels.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic retune(cfg_type s);
      wait_idle();
      apply_settings(s);
   endtask

   // completes a partial row (with flushes if a row is held), then flushes out the held row
   task automatic drain_rows();
      while (col_pos != 0 || have_prev)
         send_item(have_prev ? KIND_FLUSH : KIND_PIXEL, any_pixel());
   endtask

   task automatic settle(cfg_type s);
      drain_rows();
      retune(s);
   endtask

   // narrowing only: the held row stays fully written for the new width
   task automatic shrink_width();
      cfg_type s;
      s = shadow_cfg;
      s.image_width = COL_CFG_W'($urandom_range(0, active_width()));
      retune(s);
   endtask

   task automatic send_noisy_row();
      do begin
         if (!have_prev && $urandom_range(0, 19) == 0)
            send_item(KIND_FLUSH, any_pixel());
         if (have_prev && $urandom_range(0, 59) == 0) begin
            drain_rows();
            return;
         end
         if (col_pos != 0 && $urandom_range(0, 149) == 0)
            shrink_width();
         send_item(KIND_PIXEL, any_pixel());
      end while (col_pos != 0);
   endtask

   task automatic tweak_between_rows();
      cfg_type s;
      int      w;
      s = shadow_cfg;
      w = active_width();
      case ($urandom_range(0, 2))
         0: s.image_height = ROW_CFG_W'($urandom_range(1, (row_idx == 0) ? 1 : row_idx));
         1: begin
            s.left_col   = COL_CFG_W'($urandom_range(0, w + 1));
            s.right_col  = COL_CFG_W'($urandom_range(0, w + 1));
            s.top_row    = ROW_CFG_W'($urandom_range(0, 65535));
            s.bottom_row = ROW_CFG_W'($urandom_range(0, 65535));
            if ($urandom_range(0, 1) == 0) begin
               s.top_row    = 0;
               s.bottom_row = s.image_height;
            end
         end
         default: s.image_width = COL_CFG_W'($urandom_range(0, w));
      endcase
      retune(s);
   endtask

   task automatic test_flush_without_row();
      settle(make_cfg(2, 2, 1, 2, 1, 2));
      send_item(KIND_FLUSH, any_pixel());
      send_item(KIND_FLUSH, any_pixel());
      send_item(KIND_PIXEL, any_pixel());
      send_item(KIND_FLUSH, any_pixel());
      drain_rows();
   endtask

   task automatic test_pixel_extremes();
      settle(make_cfg(3, 3, 1, 3, 1, 3));
      send_item(KIND_PIXEL, 24'h000000);
      send_item(KIND_PIXEL, 24'hFFFFFF);
      send_item(KIND_PIXEL, 24'h800001);
      send_item(KIND_PIXEL, 24'h7FFFFE);
      send_item(KIND_PIXEL, 24'hFFFFFF);
      send_item(KIND_PIXEL, 24'h000000);
      drain_rows();
   endtask

   task automatic test_width_zero();
      settle(make_cfg(0, 1, 1, 1, 1, 1));
      repeat (3) send_item(KIND_PIXEL, any_pixel());
      drain_rows();
   endtask

   task automatic test_bad_spans();
      settle(make_cfg(2, 2, 0, 2, 1, 2));
      repeat (4) send_item(KIND_PIXEL, any_pixel());
      settle(make_cfg(2, 2, 2, 1, 1, 2));
      repeat (4) send_item(KIND_PIXEL, any_pixel());
      settle(make_cfg(2, 2, 1, 3, 1, 2));
      repeat (4) send_item(KIND_PIXEL, any_pixel());
      drain_rows();
   endtask

   task automatic test_row_wrap();
      settle(make_cfg(2, 2, 1, 2, 2, 2));
      repeat (2) send_item(KIND_PIXEL, any_pixel());
      // lowered height: the next row number comes out as zero
      retune(make_cfg(2, 1, 1, 2, 0, 1));
      repeat (4) send_item(KIND_PIXEL, any_pixel());
      settle(make_cfg(2, 65535, 1, 2, 65535, 65535));
      repeat (4) send_item(KIND_PIXEL, any_pixel());
      drain_rows();
   endtask

   task automatic test_width_shrink();
      settle(make_cfg(4, 3, 1, 4, 1, 3));
      repeat (7) send_item(KIND_PIXEL, any_pixel());
      retune(make_cfg(2, 3, 1, 2, 1, 3));
      send_item(KIND_PIXEL, any_pixel());
      drain_rows();
   endtask

   task automatic test_backpressure();
      settle(make_cfg(5, 4, 2, 4, 1, 4));
      tx_gaps = 1'b0;
      hold_token++;
      repeat (40) send_item(KIND_PIXEL, any_pixel());
      drain_rows();
      tx_gaps = 1'b1;
   endtask

   task automatic test_widest_row();
      settle(make_cfg(4095, 2, 1, 2048, 1, 2));
      repeat (MAX_W) send_item(KIND_PIXEL, any_pixel());
      retune(make_cfg(4, 2, 1, 4, 1, 2));
      repeat (8) send_item(KIND_PIXEL, any_pixel());
      drain_rows();
   endtask

   task automatic test_random_frames(int goal);
      int stop_at;
      stop_at = stream_count + goal;
      while (stream_count < stop_at) begin
         if (stream_count + 200 >= stop_at) begin
            tx_gaps = 1'b0;
            rx_gaps = 1'b0;
         end else begin
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
         end
         settle(random_cfg());
         repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 7) == 0) tweak_between_rows();
            send_noisy_row();
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_flush_without_row();
      test_pixel_extremes();
      test_width_zero();
      test_bad_spans();
      test_row_wrap();
      test_width_shrink();
      test_backpressure();
      test_widest_row();
      test_random_frames(1650);
      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("** scanline_region_mirror_core: PASSED **");
      else
         $display("** scanline_region_mirror_core: FAILED **");
      $finish;
   end

   always @(posedge clock) begin
      if (hold_token != hold_token_seen) begin
         hold_token_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic check_field(string name, logic [PIXEL_W-1:0] want, logic [PIXEL_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_pixels.size() == 0) begin
            $display("%0t: unexpected item: expected none, actual %h", $time, rsp_item);
            mismatch_count++;
         end else begin
            due_head = due_pixels.pop_front();
            check_field("out_valid", PIXEL_W'(due_head.out_valid),
                        PIXEL_W'(rsp_item.out_valid));
            check_field("out_pixel", due_head.out_pixel, rsp_item.out_pixel);
            check_field("end_of_row", PIXEL_W'(due_head.end_of_row),
                        PIXEL_W'(rsp_item.end_of_row));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("** scanline_region_mirror_core: FAILED **");
         $finish;
      end else begin
         quiet_cycles++;
      end
   end

endmodule
